### rtl/wvc_pkg.sv
// Package for the waypoint velocity controller: fixed-point widths, register
// indexes, state types and the rotation-matrix term selection.
// Used by the top level, the lanes and the merge stage; depends on nothing.
package wvc_pkg;

    // Fraction bits of positions, quaternion parts and gain.
    localparam int POS_FRAC_BITS  = 16;
    localparam int QUAT_FRAC_BITS = 14;
    localparam int GAIN_FRAC_BITS = 12;

    // Port widths fixed by the interface.
    localparam int COORD_W = 32;
    localparam int QUAT_W  = 16;
    localparam int GAIN_W  = 16;
    localparam int IDX_W   = 3;

    // Internal widths, derived from the fraction bit counts.
    localparam int QP_W  = 2 * QUAT_W;
    localparam int RAW_W = ((2 * QUAT_FRAC_BITS + 1 > QP_W) ?
                            (2 * QUAT_FRAC_BITS + 1) : QP_W) + 3;
    localparam int ROT_W = RAW_W + 1 - QUAT_FRAC_BITS;
    localparam int TP_W  = ROT_W + COORD_W;
    localparam int ACC_W = TP_W + 2;
    localparam int MR_W  = ACC_W + 1 - QUAT_FRAC_BITS;
    localparam int MAP_W = MR_W + 1;
    localparam int E_W   = MAP_W + 1;
    localparam int GP_W  = E_W + GAIN_W + 1;
    localparam int VR_W  = GP_W + 1 - GAIN_FRAC_BITS;
    localparam int SQ_W  = 2 * (POS_FRAC_BITS + 2);

    // Fixed-point constants.
    localparam logic signed [RAW_W-1:0] ROT_ONE =
        RAW_W'(64'd1 << (2 * QUAT_FRAC_BITS));
    localparam longint ROT_HALF  = longint'(1) << (QUAT_FRAC_BITS - 1);
    localparam longint GAIN_HALF = longint'(1) << (GAIN_FRAC_BITS - 1);
    localparam longint POS_ONE   = longint'(1) << POS_FRAC_BITS;
    localparam longint POS_HALF  = longint'(1) << (POS_FRAC_BITS - 1);
    // 0.09 square metres, rounded to 2*POS_FRAC_BITS fraction bits.
    localparam longint ARRIVE_SQ = ((longint'(9) << (2 * POS_FRAC_BITS)) + 50) / 100;

    // Configuration register indexes.
    localparam logic [IDX_W-1:0] REG_OFFSET_X   = 3'd0;
    localparam logic [IDX_W-1:0] REG_OFFSET_Y   = 3'd1;
    localparam logic [IDX_W-1:0] REG_OFFSET_Z   = 3'd2;
    localparam logic [IDX_W-1:0] REG_QUAT_W     = 3'd3;
    localparam logic [IDX_W-1:0] REG_QUAT_X     = 3'd4;
    localparam logic [IDX_W-1:0] REG_QUAT_Y     = 3'd5;
    localparam logic [IDX_W-1:0] REG_QUAT_Z     = 3'd6;
    localparam logic [IDX_W-1:0] REG_SPEED_GAIN = 3'd7;

    // Input command codes.
    localparam logic CMD_TICK     = 1'b0;
    localparam logic CMD_WAYPOINT = 1'b1;

    // Quaternion part indexes and the last matrix column.
    localparam logic [1:0] Q_W = 2'd0;
    localparam logic [1:0] Q_X = 2'd1;
    localparam logic [1:0] Q_Y = 2'd2;
    localparam logic [1:0] Q_Z = 2'd3;
    localparam logic [1:0] LAST_COL = 2'd2;

    // Top-level sequencer states.
    typedef enum logic [1:0] {
        TS_IDLE,
        TS_LANES,
        TS_MERGE,
        TS_LOAD
    } top_state_t;

    // Per-lane phases: five per matrix column, then map, error and gain.
    typedef enum logic [3:0] {
        LP_IDLE,
        LP_MUL_AB,
        LP_MUL_CD,
        LP_FORM,
        LP_MUL_T,
        LP_ACC,
        LP_MAP,
        LP_ERR,
        LP_MUL_G,
        LP_VEL
    } lane_phase_t;

    // Control from the sequencer to the lanes and the merge stage.
    typedef struct packed {
        logic start;
    } lane_ctl_t;

    // Selection of one rotation matrix entry: base + s*(a*b +/- c*d).
    typedef struct packed {
        logic [1:0] a;
        logic [1:0] b;
        logic [1:0] c;
        logic [1:0] d;
        logic       diag;
        logic       neg;
    } rot_sel_t;

    // Terms of entry (row, col) of the unit-quaternion rotation matrix.
    function automatic rot_sel_t rot_sel(input logic [1:0] row, input logic [1:0] col);
        rot_sel_t s;
        s = '{a: Q_X, b: Q_X, c: Q_Y, d: Q_Y, diag: 1'b1, neg: 1'b0};
        case ({row, col})
            4'b0000: s = '{a: Q_Y, b: Q_Y, c: Q_Z, d: Q_Z, diag: 1'b1, neg: 1'b0};
            4'b0001: s = '{a: Q_X, b: Q_Y, c: Q_W, d: Q_Z, diag: 1'b0, neg: 1'b1};
            4'b0010: s = '{a: Q_X, b: Q_Z, c: Q_W, d: Q_Y, diag: 1'b0, neg: 1'b0};
            4'b0100: s = '{a: Q_X, b: Q_Y, c: Q_W, d: Q_Z, diag: 1'b0, neg: 1'b0};
            4'b0101: s = '{a: Q_X, b: Q_X, c: Q_Z, d: Q_Z, diag: 1'b1, neg: 1'b0};
            4'b0110: s = '{a: Q_Y, b: Q_Z, c: Q_W, d: Q_X, diag: 1'b0, neg: 1'b1};
            4'b1000: s = '{a: Q_X, b: Q_Z, c: Q_W, d: Q_Y, diag: 1'b0, neg: 1'b1};
            4'b1001: s = '{a: Q_Y, b: Q_Z, c: Q_W, d: Q_X, diag: 1'b0, neg: 1'b0};
            4'b1010: s = '{a: Q_X, b: Q_X, c: Q_Y, d: Q_Y, diag: 1'b1, neg: 1'b0};
            default: s = '{a: Q_X, b: Q_X, c: Q_Y, d: Q_Y, diag: 1'b1, neg: 1'b0};
        endcase
        return s;
    endfunction

endpackage

### rtl/waypoint_velocity_controller.sv
// Top level of the waypoint velocity controller: configuration registers,
// target and mode state, the item sequencer and the output register.
// Depends on wvc_pkg, wvc_lane and wvc_merge.
//
// One word in gives one word out. For a control tick, the three axis lanes
// each walk their row of the rotation matrix with one multiplier per product
// type, then map, error and gain, and the merge stage adds the arrival test
// before the result is loaded. A waypoint word goes straight to the load
// state and is loaded into the output register once that register is free.
// The block works on one word at a time; s_ready is high whenever the
// sequencer is idle, even while a finished result still waits in the output
// register. Configuration writes are always taken and must only be issued
// while the block is idle.
module waypoint_velocity_controller (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic                              s_cmd,
    input  logic signed [wvc_pkg::COORD_W-1:0] s_coord_x,
    input  logic signed [wvc_pkg::COORD_W-1:0] s_coord_y,
    input  logic signed [wvc_pkg::COORD_W-1:0] s_coord_z,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic signed [wvc_pkg::COORD_W-1:0] m_vel_x,
    output logic signed [wvc_pkg::COORD_W-1:0] m_vel_y,
    output logic signed [wvc_pkg::COORD_W-1:0] m_vel_z,
    output logic                              m_arrived,
    output logic                              m_nav_mode,
    output logic                              m_waypoint_ack,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [wvc_pkg::IDX_W-1:0]         cfg_index,
    input  logic [wvc_pkg::COORD_W-1:0]       cfg_data
);
    import wvc_pkg::*;

    top_state_t state_reg, state_next;

    logic signed [COORD_W-1:0] offset_reg [3];
    logic signed [QUAT_W-1:0]  quat_reg [4];
    logic [GAIN_W-1:0]         gain_reg;
    logic signed [COORD_W-1:0] target_reg [3];
    logic signed [COORD_W-1:0] pos_reg [3];
    logic                      mode_reg;
    logic                      ack_reg;
    logic                      start_reg;
    logic                      arrived_reg;

    logic                      in_take, out_load;
    lane_ctl_t                 lane_ctl, merge_ctl;
    logic                      lane_done [3];
    logic signed [E_W-1:0]     lane_err [3];
    logic signed [COORD_W-1:0] lane_vel [3];
    logic                      merge_done, merge_arrived;

    logic                      m_valid_reg;
    logic signed [COORD_W-1:0] m_vel_reg [3];
    logic                      m_arrived_reg, m_nav_reg, m_ack_reg;

    assign s_ready   = (state_reg == TS_IDLE);
    assign cfg_ready = 1'b1;
    assign in_take   = s_valid && s_ready;
    assign out_load  = (state_reg == TS_LOAD) && (!m_valid_reg || m_ready);

    // Sequencer next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            TS_IDLE:  if (in_take) state_next = (s_cmd == CMD_WAYPOINT) ? TS_LOAD : TS_LANES;
            TS_LANES: if (lane_done[0]) state_next = TS_MERGE;
            TS_MERGE: if (merge_done) state_next = TS_LOAD;
            TS_LOAD:  if (out_load) state_next = TS_IDLE;
            default:  state_next = TS_IDLE;
        endcase
    end

    // Sequencer outputs to the lanes and the merge stage.
    always_comb begin
        lane_ctl.start  = start_reg;
        merge_ctl.start = (state_reg == TS_LANES) && lane_done[0];
    end

    // Control state: sequencer, lane start, mode, output valid.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= TS_IDLE;
            start_reg   <= 1'b0;
            mode_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            start_reg <= in_take && (s_cmd == CMD_TICK);
            if (out_load && !ack_reg && arrived_reg) begin
                mode_reg <= 1'b1;
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            offset_reg[0] <= -32'sd66191;
            offset_reg[1] <= -32'sd64221;
            offset_reg[2] <= -32'sd6833;
            quat_reg[0]   <= 16'sd16384;
            quat_reg[1]   <= -16'sd7;
            quat_reg[2]   <= 16'sd0;
            quat_reg[3]   <= 16'sd0;
            gain_reg      <= 16'd3277;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_OFFSET_X:   offset_reg[0] <= cfg_data;
                REG_OFFSET_Y:   offset_reg[1] <= cfg_data;
                REG_OFFSET_Z:   offset_reg[2] <= cfg_data;
                REG_QUAT_W:     quat_reg[0]   <= cfg_data[QUAT_W-1:0];
                REG_QUAT_X:     quat_reg[1]   <= cfg_data[QUAT_W-1:0];
                REG_QUAT_Y:     quat_reg[2]   <= cfg_data[QUAT_W-1:0];
                REG_QUAT_Z:     quat_reg[3]   <= cfg_data[QUAT_W-1:0];
                REG_SPEED_GAIN: gain_reg      <= cfg_data[GAIN_W-1:0];
                default:        gain_reg      <= gain_reg;
            endcase
        end
    end

    // Target store; takeoff mode rewrites it on every tick.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            target_reg[0] <= '0;
            target_reg[1] <= '0;
            target_reg[2] <= '0;
        end else if (in_take) begin
            if (s_cmd == CMD_WAYPOINT) begin
                target_reg[0] <= s_coord_x;
                target_reg[1] <= s_coord_y;
                target_reg[2] <= s_coord_z;
            end else if (!mode_reg) begin
                target_reg[0] <= (offset_reg[0] == 32'sh80000000) ? 32'sh7fffffff
                                                                 : -offset_reg[0];
                target_reg[1] <= (offset_reg[1] == 32'sh80000000) ? 32'sh7fffffff
                                                                 : -offset_reg[1];
                target_reg[2] <= COORD_W'(POS_ONE);
            end
        end
    end

    // Word payload held while it is worked on, and the arrival result of its tick.
    always_ff @(posedge aclk) begin
        if (in_take) begin
            pos_reg[0] <= s_coord_x;
            pos_reg[1] <= s_coord_y;
            pos_reg[2] <= s_coord_z;
            ack_reg    <= (s_cmd == CMD_WAYPOINT);
        end
        if (merge_done) begin
            arrived_reg <= merge_arrived;
        end else if (in_take) begin
            arrived_reg <= 1'b0;
        end
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_nav_reg <= 1'b0;
        end else if (out_load) begin
            m_nav_reg <= mode_reg || (!ack_reg && arrived_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_vel_reg[0]  <= ack_reg ? '0 : lane_vel[0];
            m_vel_reg[1]  <= ack_reg ? '0 : lane_vel[1];
            m_vel_reg[2]  <= ack_reg ? '0 : lane_vel[2];
            m_arrived_reg <= !ack_reg && arrived_reg;
            m_ack_reg     <= ack_reg;
        end
    end

    // Three axis lanes working side by side.
    for (genvar i = 0; i < 3; i++) begin : g_lane
        wvc_lane u_lane (
            .aclk    (aclk),
            .aresetn (aresetn),
            .ctl     (lane_ctl),
            .row     (2'(i)),
            .quat    (quat_reg),
            .tgt     (target_reg),
            .offset  (offset_reg[i]),
            .pos     (pos_reg[i]),
            .gain    (gain_reg),
            .done    (lane_done[i]),
            .err     (lane_err[i]),
            .vel     (lane_vel[i])
        );
    end

    wvc_merge u_merge (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (merge_ctl),
        .err_x   (lane_err[0]),
        .err_y   (lane_err[1]),
        .err_z   (lane_err[2]),
        .done    (merge_done),
        .arrived (merge_arrived)
    );

    assign m_valid        = m_valid_reg;
    assign m_vel_x        = m_vel_reg[0];
    assign m_vel_y        = m_vel_reg[1];
    assign m_vel_z        = m_vel_reg[2];
    assign m_arrived      = m_arrived_reg;
    assign m_nav_mode     = m_nav_reg;
    assign m_waypoint_ack = m_ack_reg;

endmodule

### rtl/wvc_lane.sv
// One axis lane: forms its row of the rotation matrix, maps the target,
// and computes the axis error and the saturated velocity.
// Depends on wvc_pkg.
module wvc_lane (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  wvc_pkg::lane_ctl_t                ctl,
    input  logic [1:0]                        row,
    input  logic signed [wvc_pkg::QUAT_W-1:0] quat [4],
    input  logic signed [wvc_pkg::COORD_W-1:0] tgt [3],
    input  logic signed [wvc_pkg::COORD_W-1:0] offset,
    input  logic signed [wvc_pkg::COORD_W-1:0] pos,
    input  logic [wvc_pkg::GAIN_W-1:0]        gain,
    output logic                              done,
    output logic signed [wvc_pkg::E_W-1:0]    err,
    output logic signed [wvc_pkg::COORD_W-1:0] vel
);
    import wvc_pkg::*;

    lane_phase_t phase_reg, phase_next;
    logic [1:0]  col_reg;
    rot_sel_t    sel;

    logic signed [QUAT_W-1:0]  qa, qb;
    logic signed [QP_W-1:0]    qprod_reg, t1_reg;
    logic signed [QP_W:0]      pair;
    logic signed [RAW_W-1:0]   dbl, raw;
    logic signed [RAW_W:0]     r_rnd;
    logic signed [ROT_W-1:0]   r_reg;
    logic signed [TP_W-1:0]    tprod_reg;
    logic signed [ACC_W-1:0]   acc_reg;
    logic signed [ACC_W:0]     acc_rnd;
    logic signed [MAP_W-1:0]   m_reg;
    logic signed [E_W-1:0]     e_reg;
    logic signed [GP_W-1:0]    gprod_reg;
    logic signed [GP_W:0]      v_rnd;
    logic signed [VR_W-1:0]    v_sh;

    always_comb sel = rot_sel(row, col_reg);

    // Phase sequencing.
    always_comb begin
        phase_next = phase_reg;
        case (phase_reg)
            LP_IDLE:   if (ctl.start) phase_next = LP_MUL_AB;
            LP_MUL_AB: phase_next = LP_MUL_CD;
            LP_MUL_CD: phase_next = LP_FORM;
            LP_FORM:   phase_next = LP_MUL_T;
            LP_MUL_T:  phase_next = LP_ACC;
            LP_ACC:    phase_next = (col_reg == LAST_COL) ? LP_MAP : LP_MUL_AB;
            LP_MAP:    phase_next = LP_ERR;
            LP_ERR:    phase_next = LP_MUL_G;
            LP_MUL_G:  phase_next = LP_VEL;
            LP_VEL:    phase_next = LP_IDLE;
            default:   phase_next = LP_IDLE;
        endcase
    end

    // Multiplier operand selection for the quaternion products.
    always_comb begin
        if (phase_reg == LP_MUL_CD) begin
            qa = quat[sel.c];
            qb = quat[sel.d];
        end else begin
            qa = quat[sel.a];
            qb = quat[sel.b];
        end
    end

    // Matrix entry: base + s*(a*b +/- c*d), rounded to QUAT_FRAC_BITS.
    always_comb begin
        pair  = sel.neg ? ((QP_W+1)'(t1_reg) - (QP_W+1)'(qprod_reg))
                        : ((QP_W+1)'(t1_reg) + (QP_W+1)'(qprod_reg));
        dbl   = RAW_W'(pair) <<< 1;
        raw   = sel.diag ? (ROT_ONE - dbl) : dbl;
        r_rnd = (RAW_W+1)'(raw) + (RAW_W+1)'(ROT_HALF);
    end

    // Rounding of the mapped coordinate and of the velocity.
    always_comb begin
        acc_rnd = (ACC_W+1)'(acc_reg) + (ACC_W+1)'(ROT_HALF);
        v_rnd   = (GP_W+1)'(gprod_reg) + (GP_W+1)'(GAIN_HALF);
        v_sh    = VR_W'(v_rnd >>> GAIN_FRAC_BITS);
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= LP_IDLE;
            col_reg   <= '0;
        end else begin
            phase_reg <= phase_next;
            if (ctl.start) begin
                col_reg <= '0;
            end else if (phase_reg == LP_ACC) begin
                col_reg <= col_reg + 2'd1;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge aclk) begin
        qprod_reg <= qa * qb;
        tprod_reg <= r_reg * tgt[col_reg];
        gprod_reg <= e_reg * $signed({1'b0, gain});
        if (phase_reg == LP_MUL_CD) begin
            t1_reg <= qprod_reg;
        end
        if (phase_reg == LP_FORM) begin
            r_reg <= ROT_W'(r_rnd >>> QUAT_FRAC_BITS);
        end
        if (ctl.start) begin
            acc_reg <= '0;
        end else if (phase_reg == LP_ACC) begin
            acc_reg <= acc_reg + ACC_W'(tprod_reg);
        end
        if (phase_reg == LP_MAP) begin
            m_reg <= MAP_W'(MR_W'(acc_rnd >>> QUAT_FRAC_BITS)) + MAP_W'(offset);
        end
        if (phase_reg == LP_ERR) begin
            e_reg <= E_W'(m_reg) - E_W'(pos);
        end
    end

    // Saturate the velocity to the 32-bit range.
    always_comb begin
        if (v_sh > VR_W'(32'sh7fffffff)) begin
            vel = 32'sh7fffffff;
        end else if (v_sh < VR_W'(32'sh80000000)) begin
            vel = 32'sh80000000;
        end else begin
            vel = COORD_W'(v_sh);
        end
    end

    assign done = (phase_reg == LP_VEL);
    assign err  = e_reg;

endmodule

### rtl/wvc_merge.sv
// Merge stage: combines the three lane errors into the arrival flag
// (horizontal squared error and vertical tolerance).
// Depends on wvc_pkg.
module wvc_merge (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  wvc_pkg::lane_ctl_t             ctl,
    input  logic signed [wvc_pkg::E_W-1:0] err_x,
    input  logic signed [wvc_pkg::E_W-1:0] err_y,
    input  logic signed [wvc_pkg::E_W-1:0] err_z,
    output logic                           done,
    output logic                           arrived
);
    import wvc_pkg::*;

    localparam int SX_W = POS_FRAC_BITS + 2;

    logic                    in_box;
    logic                    stage1_reg, stage2_reg;
    logic                    box_reg;
    logic signed [SQ_W-1:0]  sqx_reg, sqy_reg;
    logic        [SQ_W:0]    sq_sum;
    logic                    arrived_reg;

    // Per-axis bounds, all strict.
    always_comb begin
        in_box = (err_x > -E_W'(POS_ONE)) && (err_x < E_W'(POS_ONE)) &&
                 (err_y > -E_W'(POS_ONE)) && (err_y < E_W'(POS_ONE)) &&
                 (err_z > -E_W'(POS_HALF)) && (err_z < E_W'(POS_HALF));
    end

    always_comb sq_sum = {1'b0, sqx_reg} + {1'b0, sqy_reg};

    // Stage valids.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stage1_reg <= 1'b0;
            stage2_reg <= 1'b0;
        end else begin
            stage1_reg <= ctl.start;
            stage2_reg <= stage1_reg;
        end
    end

    // Squares, then the threshold compare.
    always_ff @(posedge aclk) begin
        if (ctl.start) begin
            box_reg <= in_box;
            sqx_reg <= SX_W'(err_x) * SX_W'(err_x);
            sqy_reg <= SX_W'(err_y) * SX_W'(err_y);
        end
        if (stage1_reg) begin
            arrived_reg <= box_reg && (sq_sum < (SQ_W+1)'(ARRIVE_SQ));
        end
    end

    assign done    = stage2_reg;
    assign arrived = arrived_reg;

endmodule

### rtl/wvc_checker.sv
// Port-level checker for the waypoint velocity controller, bound to the top.
// Depends on the top level's port list only.
module wvc_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_valid,
    input logic        m_ready,
    input logic [31:0] m_vel_x,
    input logic [31:0] m_vel_y,
    input logic [31:0] m_vel_z,
    input logic        m_arrived,
    input logic        m_nav_mode,
    input logic        m_waypoint_ack
);

    // A stalled result word stays valid and keeps its x and z velocities and its mode flag.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_vel_x) && $stable(m_vel_z)
                                && $stable(m_nav_mode))
        else $error("result word changed while stalled");

    // A waypoint acknowledgement carries no motion and no arrival.
    a_ack: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_waypoint_ack |-> m_vel_x == 32'd0 && m_vel_y == 32'd0 &&
                                      m_vel_z == 32'd0 && !m_arrived)
        else $error("waypoint acknowledgement with nonzero result");

    // Arrival always leaves the block in navigate mode.
    a_arrive: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_arrived |-> m_nav_mode)
        else $error("arrival reported outside navigate mode");

    // Navigate mode is never left except by reset.
    a_mode: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) |-> !$fell(m_nav_mode))
        else $error("navigate mode dropped");

endmodule

bind waypoint_velocity_controller wvc_checker u_wvc_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_vel_x        (m_vel_x),
    .m_vel_y        (m_vel_y),
    .m_vel_z        (m_vel_z),
    .m_arrived      (m_arrived),
    .m_nav_mode     (m_nav_mode),
    .m_waypoint_ack (m_waypoint_ack)
);

### bench/testbench.sv
// Self-checking bench for waypoint_velocity_controller: directed and random words
// are checked against a fixed-point predictor of the tick and waypoint paths.
// Depends on wvc_pkg and the RTL under rtl/.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import wvc_pkg::*;

    // One result word as the block presents it.
    typedef struct packed {
        logic signed [31:0] vx;
        logic signed [31:0] vy;
        logic signed [31:0] vz;
        logic               arrived;
        logic               nav;
        logic               ack;
    } velocity_t;

    // Tracks configuration, target and mode; predicts and checks result words.
    class wvc_scoreboard;
        int          offs[3];
        int          quat[4];
        int unsigned gain;
        bit          nav;
        int          tgt[3];
        velocity_t   pending_q[$];
        int          mismatches;
        int          arrivals;
        int          waypoints;
        int          ticks;

        function new();
            offs = '{-66191, -64221, -6833};
            quat = '{16384, -7, 0, 0};
            gain = 3277;
            nav  = 1'b0;
            tgt  = '{0, 0, 0};
        endfunction

        function void set_reg(logic [IDX_W-1:0] idx, logic [31:0] d);
            case (idx)
                REG_OFFSET_X:   offs[0] = int'(d);
                REG_OFFSET_Y:   offs[1] = int'(d);
                REG_OFFSET_Z:   offs[2] = int'(d);
                REG_QUAT_W:     quat[0] = int'($signed(d[15:0]));
                REG_QUAT_X:     quat[1] = int'($signed(d[15:0]));
                REG_QUAT_Y:     quat[2] = int'($signed(d[15:0]));
                REG_QUAT_Z:     quat[3] = int'($signed(d[15:0]));
                REG_SPEED_GAIN: gain    = d[15:0];
                default: ;
            endcase
        endfunction

        // Round half up, dropping s fraction bits.
        function longint round_off(longint v, int s);
            return (v + (longint'(1) << (s - 1))) >>> s;
        endfunction

        function longint clip32(longint v);
            if (v > 64'sd2147483647) return 64'sd2147483647;
            if (v < -64'sd2147483648) return -64'sd2147483648;
            return v;
        endfunction

        // Target used by the next tick: the takeoff point or the stored waypoint.
        function void tick_target(output int t[3]);
            if (nav) begin
                t = tgt;
            end else begin
                t[0] = int'(clip32(-longint'(offs[0])));
                t[1] = int'(clip32(-longint'(offs[1])));
                t[2] = 1 << POS_FRAC_BITS;
            end
        endfunction

        // Rotate the point by the quaternion matrix, then translate it.
        function void map_point(input int t[3], output longint m[3]);
            longint w, x, y, z, one, acc;
            longint r[9];
            w = quat[0]; x = quat[1]; y = quat[2]; z = quat[3];
            one = longint'(1) << (2 * QUAT_FRAC_BITS);
            r[0] = one - 2 * (y * y + z * z);
            r[1] = 2 * (x * y - w * z);
            r[2] = 2 * (x * z + w * y);
            r[3] = 2 * (x * y + w * z);
            r[4] = one - 2 * (x * x + z * z);
            r[5] = 2 * (y * z - w * x);
            r[6] = 2 * (x * z - w * y);
            r[7] = 2 * (y * z + w * x);
            r[8] = one - 2 * (x * x + y * y);
            for (int i = 0; i < 9; i++) r[i] = round_off(r[i], QUAT_FRAC_BITS);
            for (int i = 0; i < 3; i++) begin
                acc = r[3*i] * t[0] + r[3*i+1] * t[1] + r[3*i+2] * t[2];
                m[i] = round_off(acc, QUAT_FRAC_BITS) + offs[i];
            end
        endfunction

        function void aim(output longint m[3]);
            int t[3];
            tick_target(t);
            map_point(t, m);
        endfunction

        // Note an accepted input word and queue the word it must produce.
        function void note_input(logic cmd, int p[3]);
            velocity_t r;
            longint m[3], e[3], sq;
            longint unit_len;
            r = '0;
            if (cmd == CMD_WAYPOINT) begin
                tgt = p;
                r.nav = nav;
                r.ack = 1'b1;
                waypoints++;
            end else begin
                tick_target(tgt);
                map_point(tgt, m);
                for (int i = 0; i < 3; i++) e[i] = m[i] - p[i];
                r.vx = clip32(round_off(e[0] * longint'(gain), GAIN_FRAC_BITS));
                r.vy = clip32(round_off(e[1] * longint'(gain), GAIN_FRAC_BITS));
                r.vz = clip32(round_off(e[2] * longint'(gain), GAIN_FRAC_BITS));
                unit_len = longint'(1) << POS_FRAC_BITS;
                if (e[0] > -unit_len && e[0] < unit_len && e[1] > -unit_len &&
                    e[1] < unit_len && e[2] > -(unit_len / 2) && e[2] < unit_len / 2) begin
                    sq = e[0] * e[0] + e[1] * e[1];
                    r.arrived = sq < ARRIVE_SQ;
                end
                if (r.arrived) begin
                    nav = 1'b1;
                    arrivals++;
                end
                r.nav = nav;
                ticks++;
            end
            pending_q.push_back(r);
        endfunction

        function void report(string msg);
            mismatches++;
            if (mismatches <= 10) $display("%s", msg);
        endfunction

        // Compare an accepted result word with the oldest prediction.
        function void check_result(velocity_t got);
            velocity_t want;
            if (pending_q.size() == 0) begin
                report($sformatf("unexpected result word vel=%0d,%0d,%0d",
                                 got.vx, got.vy, got.vz));
                return;
            end
            want = pending_q.pop_front();
            if (got != want)
                report($sformatf({"mismatch: expected vel=%0d,%0d,%0d arr=%0b nav=%0b",
                                  " ack=%0b, got vel=%0d,%0d,%0d arr=%0b nav=%0b ack=%0b"},
                                 want.vx, want.vy, want.vz, want.arrived, want.nav, want.ack,
                                 got.vx, got.vy, got.vz, got.arrived, got.nav, got.ack));
        endfunction
    endclass

    logic              aclk;
    logic              aresetn;
    logic              s_valid;
    logic              s_ready;
    logic              s_cmd;
    logic signed [31:0] s_coord_x, s_coord_y, s_coord_z;
    logic              m_valid;
    logic              m_ready;
    logic signed [31:0] m_vel_x, m_vel_y, m_vel_z;
    logic              m_arrived, m_nav_mode, m_waypoint_ack;
    logic              cfg_valid;
    logic              cfg_ready;
    logic [IDX_W-1:0]  cfg_index;
    logic [31:0]       cfg_data;

    wvc_scoreboard sb;
    bit            gaps_on;
    bit            hold_req;
    int            held_cycles;

    waypoint_velocity_controller dut (.*);

    // 2 ns clock.
    always begin
        aclk = 1'b0;
        #1;
        aclk = 1'b1;
        #1;
    end

    // Hard limit on the run.
    initial begin
        #2_000_000;
        $display("testbench: done, errors");
        $finish;
    end

    // Send one input word after a random gap when gaps are on, holding it until accepted.
    task automatic send_word(logic cmd, int x, int y, int z);
        int gap;
        gap = gaps_on ? $urandom_range(11) : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_cmd     <= cmd;
        s_coord_x <= x;
        s_coord_y <= y;
        s_coord_z <= z;
        do @(posedge aclk); while (!s_ready);
        sb.note_input(cmd, '{x, y, z});
    endtask

    // Tick with a position scattered around the point the block aims for.
    task automatic send_near_tick(int spread);
        longint m[3];
        int p[3];
        sb.aim(m);
        for (int i = 0; i < 3; i++)
            p[i] = int'(sb.clip32(m[i] + longint'($urandom_range(2 * spread))
                                  - longint'(spread)));
        send_word(CMD_TICK, p[0], p[1], p[2]);
    endtask

    task automatic write_reg(logic [IDX_W-1:0] idx, logic [31:0] d);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d;
        do @(posedge aclk); while (!cfg_ready);
        sb.set_reg(idx, d);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic write_all(int ox, int oy, int oz, int qw, int qx, int qy, int qz,
                             int g);
        write_reg(REG_OFFSET_X, ox);
        write_reg(REG_OFFSET_Y, oy);
        write_reg(REG_OFFSET_Z, oz);
        write_reg(REG_QUAT_W, qw);
        write_reg(REG_QUAT_X, qx);
        write_reg(REG_QUAT_Y, qy);
        write_reg(REG_QUAT_Z, qz);
        write_reg(REG_SPEED_GAIN, g);
    endtask

    // Let every predicted word drain, then allow for the tick latency.
    task automatic wait_idle();
        if (s_valid) s_valid <= 1'b0;
        while (sb.pending_q.size() != 0) @(posedge aclk);
        repeat (30) @(posedge aclk);
    endtask

    // Result side: random stalls, one long hold on request, check on acceptance.
    initial begin
        int stall;
        m_ready = 1'b0;
        @(posedge aresetn);
        forever begin
            stall = gaps_on ? $urandom_range(11) : 0;
            if (hold_req) begin
                hold_req = 1'b0;
                stall = 400;
            end
            if (stall > 0) begin
                m_ready <= 1'b0;
                for (int i = 0; i < stall; i++) begin
                    @(posedge aclk);
                    held_cycles++;
                end
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            sb.check_result('{m_vel_x, m_vel_y, m_vel_z, m_arrived, m_nav_mode,
                              m_waypoint_ack});
        end
    end

    // Stimulus.
    initial begin
        int kind;
        int limit;
        int rx, ry, rz;
        sb        = new();
        gaps_on   = 1'b1;
        hold_req  = 1'b0;
        aresetn   = 1'b0;
        s_valid   = 1'b0;
        s_cmd     = CMD_TICK;
        s_coord_x = '0;
        s_coord_y = '0;
        s_coord_z = '0;
        cfg_valid = 1'b0;
        cfg_index = REG_OFFSET_X;
        cfg_data  = '0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Takeoff mode at reset values, waypoints that the next tick overwrites.
        send_word(CMD_TICK, 0, 0, 0);
        send_word(CMD_TICK, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
        send_word(CMD_TICK, 32'h80000000, 32'h80000000, 32'h80000000);
        send_word(CMD_WAYPOINT, 5 << 16, -(3 << 16), 2 << 16);
        send_word(CMD_TICK, 10 << 16, 10 << 16, -(4 << 16));
        send_word(CMD_WAYPOINT, 32'h7fffffff, 32'h80000000, 32'h7fffffff);
        send_word(CMD_WAYPOINT, 32'h80000000, 32'h7fffffff, 32'h80000000);
        wait_idle();

        // Extreme registers; the most negative offset saturates the takeoff point.
        write_all(32'h80000000, 32'h7fffffff, 32'h80000000, -16384, 16384, -16384, 16384,
                  65535);
        send_word(CMD_TICK, 0, 0, 0);
        send_word(CMD_TICK, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
        send_word(CMD_TICK, 32'h80000000, 32'h80000000, 32'h80000000);
        wait_idle();
        write_all(32'h7fffffff, 32'h80000000, 32'h7fffffff, 16384, 0, 0, 0, 0);
        send_word(CMD_TICK, 1 << 16, 2 << 16, 3 << 16);
        wait_idle();

        // Back to reset values: arrive at the takeoff point and switch mode.
        write_all(-66191, -64221, -6833, 16384, -7, 0, 0, 3277);
        send_near_tick(0);
        send_near_tick(0);
        send_word(CMD_WAYPOINT, 3 << 16, 4 << 16, 2 << 16);
        send_near_tick(0);
        send_near_tick(20000);
        send_word(CMD_TICK, 0, 0, 0);
        wait_idle();

        // Random phases, each with its own registers; one has no gaps, one a long hold.
        for (int ph = 0; ph < 7; ph++) begin
            case (ph)
                0: write_all(0, 0, 0, 16384, 0, 0, 0, 4096);
                1: write_all(32'h80000000, 32'h80000000, 32'h80000000, -16384, -16384,
                             -16384, -16384, 0);
                2: write_all(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 16384, 16384,
                             16384, 16384, 65535);
                default: write_all($urandom_range(2 * (16 << 16)) - (16 << 16),
                                   $urandom_range(2 * (16 << 16)) - (16 << 16),
                                   $urandom(),
                                   $urandom_range(32768) - 16384,
                                   $urandom_range(32768) - 16384,
                                   $urandom_range(32768) - 16384,
                                   $urandom_range(32768) - 16384,
                                   $urandom_range(65535));
            endcase
            gaps_on = (ph != 3);
            if (ph == 4) hold_req = 1'b1;
            limit = (ph < 3) ? 40 : 85;
            for (int n = 0; n < limit; n++) begin
                kind = $urandom_range(99);
                if (kind < 15) begin
                    send_word(CMD_WAYPOINT, $urandom_range(2 * (20 << 16)) - (20 << 16),
                              $urandom_range(2 * (20 << 16)) - (20 << 16),
                              $urandom_range(2 * (20 << 16)) - (20 << 16));
                end else if (kind < 20) begin
                    send_word(CMD_WAYPOINT, $urandom(), $urandom(), $urandom());
                end else if (kind < 60) begin
                    send_near_tick(39321);
                end else if (kind < 85) begin
                    send_word(CMD_TICK, $urandom_range(2 * (30 << 16)) - (30 << 16),
                              $urandom_range(2 * (30 << 16)) - (30 << 16),
                              $urandom_range(2 * (30 << 16)) - (30 << 16));
                end else begin
                    rx = $urandom();
                    ry = $urandom();
                    rz = $urandom();
                    send_word(CMD_TICK, rx, ry, rz);
                end
            end
            wait_idle();
        end
        gaps_on = 1'b1;

        // Drain with a bound, then report.
        for (int i = 0; i < 5000 && sb.pending_q.size() != 0; i++) @(posedge aclk);
        repeat (40) @(posedge aclk);
        if (sb.pending_q.size() != 0)
            sb.report($sformatf("%0d result words never arrived", sb.pending_q.size()));
        $display("run covered %0d ticks, %0d waypoints, %0d arrivals, %0d held cycles",
                 sb.ticks, sb.waypoints, sb.arrivals, held_cycles);
        $display("mismatches: %0d", sb.mismatches);
        if (sb.mismatches == 0) begin
            $display("testbench: done, clean");
        end else begin
            $display("testbench: done, errors");
        end
        $finish;
    end
endmodule
